// ===== hw/rtl/salc_pkg.sv =====
package salc_pkg;

  localparam int MaxSetBits = 6;
  localparam int MaxWays    = 8;
  localparam int NumSets    = 1 << MaxSetBits;
  localparam int AddrW      = 64;
  localparam int StampW     = 32;
  localparam int CountW     = 32;
  localparam int SetIdxW    = MaxSetBits;
  localparam int WayIdxW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 6;

  localparam logic [CfgIdxW-1:0] CfgSetBits   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockBits = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWaysInUse = 2'd2;

  // Decoded access passed from front to back
  typedef struct packed {
    logic [SetIdxW-1:0] set_idx;
    logic [AddrW-1:0]   tag;
  } access_t;

  typedef struct packed {
    logic               valid;
    logic [AddrW-1:0]   tag;
    logic [StampW-1:0]  stamp;
  } line_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [CountW-1:0] hit_total;
    logic [CountW-1:0] miss_total;
    logic [CountW-1:0] eviction_total;
  } result_t;

endpackage

// ===== hw/rtl/salc_if.sv =====
interface salc_addr_if;
  logic        valid;
  logic        ready;
  logic [63:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface salc_result_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] eviction_total;
  modport source (output valid, output hit, output evicted, output hit_total,
                  output miss_total, output eviction_total, input ready);
  modport sink (input valid, input hit, input evicted, input hit_total,
                input miss_total, input eviction_total, output ready);
endinterface

// ===== hw/rtl/salc_front.sv =====
module salc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [salc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [salc_pkg::CfgDataW-1:0] cfg_data_i,
  salc_addr_if.sink                    in_if,
  output logic                         acc_valid_o,
  input  logic                         acc_ready_i,
  output salc_pkg::access_t            acc_o,
  output logic [3:0]                   ways_o
);
  import salc_pkg::*;

  logic [2:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [3:0] ways_q;
  logic [2:0] sb;
  logic [6:0] tag_sh;
  logic [AddrW-1:0] set_field;
  logic [SetIdxW-1:0] set_mask;
  access_t    q_mem_q [2];
  logic [1:0] cnt_q;
  logic       wr_ptr_q, rd_ptr_q;
  logic       push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd1;
      block_bits_q <= 6'd1;
      ways_q       <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSetBits:   set_bits_q   <= cfg_data_i[2:0];
        CfgBlockBits: block_bits_q <= cfg_data_i;
        CfgWaysInUse: ways_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sb        = (set_bits_q > 3'(MaxSetBits)) ? 3'(MaxSetBits) : set_bits_q;
    tag_sh    = 7'(sb) + 7'(block_bits_q);
    set_field = in_if.address >> block_bits_q;
    set_mask  = SetIdxW'((7'd1 << sb) - 7'd1);
    if (ways_q == 4'd0)                ways_o = 4'd1;
    else if (ways_q > 4'(MaxWays))     ways_o = 4'(MaxWays);
    else                               ways_o = ways_q;
  end

  // Two-entry queue between decode and the tag pipeline
  assign in_if.ready = (cnt_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign pop         = acc_valid_o && acc_ready_i;
  assign acc_valid_o = (cnt_q != 2'd0);
  assign acc_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q].set_idx <= set_field[SetIdxW-1:0] & set_mask;
      q_mem_q[wr_ptr_q].tag     <= (tag_sh >= 7'd64) ? '0 : (in_if.address >> tag_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers out of step");

endmodule

// ===== hw/rtl/salc_back.sv =====
module salc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_valid_i,
  output logic              acc_ready_o,
  input  salc_pkg::access_t acc_i,
  input  logic [3:0]        ways_i,
  salc_result_if.source     out_if
);
  import salc_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_e;

  state_e             state_q;
  logic [SetIdxW-1:0] clr_idx_q;
  access_t            cur_q;
  line_t              set_mem [NumSets][MaxWays];
  line_t              rd_q [MaxWays];
  logic [StampW-1:0]  clock_q;
  logic [CountW-1:0]  hits_q, misses_q, evicts_q;
  logic               out_valid_q;
  result_t            res_q;

  logic               hit;
  logic [WayIdxW-1:0] hit_way, empty_way, lru_way, target;
  logic               have_empty, have_lru;
  logic [StampW-1:0]  lru_stamp;
  logic [StampW-1:0]  clock_d;

  always_comb begin
    hit = 1'b0; hit_way = '0; have_empty = 1'b0; empty_way = '0;
    have_lru = 1'b0; lru_way = '0; lru_stamp = '0;
    for (int w = 0; w < MaxWays; w++) begin
      if (4'(w) < ways_i && !hit) begin
        if (rd_q[w].valid) begin
          if (rd_q[w].tag == cur_q.tag) begin
            hit = 1'b1; hit_way = WayIdxW'(w);
          end else if (!have_lru || rd_q[w].stamp < lru_stamp) begin
            have_lru = 1'b1; lru_way = WayIdxW'(w); lru_stamp = rd_q[w].stamp;
          end
        end else if (!have_empty) begin
          have_empty = 1'b1; empty_way = WayIdxW'(w);
        end
      end
    end
    target  = hit ? hit_way : (have_empty ? empty_way : lru_way);
    clock_d = clock_q + 1'b1;
  end

  // One set read per access, then compare and write back; one access in flight
  assign acc_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_if.ready);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      for (int w = 0; w < MaxWays; w++) set_mem[clr_idx_q][w] <= '0;
    end else if (state_q == ST_LOOKUP) begin
      set_mem[cur_q.set_idx][target] <= '{valid: 1'b1,
        tag: hit ? rd_q[target].tag : cur_q.tag, stamp: clock_d};
    end
    if (acc_valid_i && acc_ready_o) begin
      cur_q <= acc_i;
      for (int w = 0; w < MaxWays; w++) rd_q[w] <= set_mem[acc_i.set_idx][w];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      clock_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == SetIdxW'(NumSets - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc_valid_i && acc_ready_o) state_q <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          clock_q <= clock_d;
          out_valid_q <= 1'b1;
          res_q.hit <= hit;
          res_q.evicted <= !hit && !have_empty;
          if (hit) begin
            hits_q <= hits_q + 1'b1;
            res_q.hit_total <= hits_q + 1'b1;
          end else begin
            res_q.hit_total <= hits_q;
          end
          if (!hit) begin
            misses_q <= misses_q + 1'b1;
            res_q.miss_total <= misses_q + 1'b1;
          end else begin
            res_q.miss_total <= misses_q;
          end
          if (!hit && !have_empty) begin
            evicts_q <= evicts_q + 1'b1;
            res_q.eviction_total <= evicts_q + 1'b1;
          end else begin
            res_q.eviction_total <= evicts_q;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.hit            = res_q.hit;
  assign out_if.evicted        = res_q.evicted;
  assign out_if.hit_total      = res_q.hit_total;
  assign out_if.miss_total     = res_q.miss_total;
  assign out_if.eviction_total = res_q.eviction_total;

  a_no_ready_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !acc_ready_o) else $error("accept during clear");
  a_lookup_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |=> out_valid_q) else $error("lookup lost result");
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.hit && res_q.evicted)) else $error("hit with eviction");

endmodule

// ===== hw/rtl/set_assoc_lru_cache_tags.sv =====
// Channel | dir | payload
// addr_if | in  | address[63:0]
// res_if  | out | hit, evicted, hit_total, miss_total, eviction_total
// cfg     | in  | cfg_we_i, cfg_idx_i[1:0], cfg_data_i[5:0]
// Each access passes through the tag pipeline as a set read, then compare and write back.
// The set memory has one read and one write port; one access is in flight at a time.
// After reset a clearing pass over all 64 sets (one set per cycle) runs before any access.
// A two-entry queue decouples address decode from the tag pipeline; results sit in a register.
module set_assoc_lru_cache_tags (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [salc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [salc_pkg::CfgDataW-1:0] cfg_data_i,
  salc_addr_if.sink                     addr_if,
  salc_result_if.source                 res_if
);
  import salc_pkg::*;

  logic       acc_valid, acc_ready;
  access_t    acc;
  logic [3:0] ways;

  salc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(addr_if), .acc_valid_o(acc_valid), .acc_ready_i(acc_ready),
    .acc_o(acc), .ways_o(ways)
  );

  salc_back u_back (
    .clk_i, .rst_ni, .acc_valid_i(acc_valid), .acc_ready_o(acc_ready),
    .acc_i(acc), .ways_i(ways), .out_if(res_if)
  );

endmodule
